/* design/gcdl_pkg.sv */
// Shared types and constants for the GCD / LCM unit.
package gcdl_pkg;

    localparam int OPERAND_WIDTH = 16;
    localparam int LCM_WIDTH     = 2 * OPERAND_WIDTH;
    localparam int CNT_WIDTH     = $clog2(OPERAND_WIDTH);
    localparam int QUEUE_DEPTH   = 2;
    localparam int QUEUE_AW      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CW      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [OPERAND_WIDTH-1:0] operand_a;
        logic [OPERAND_WIDTH-1:0] operand_b;
    } gcdl_in_t;

    typedef struct packed {
        logic [OPERAND_WIDTH-1:0] gcd_value;
        logic [LCM_WIDTH-1:0]     lcm_value;
    } gcdl_out_t;

    // Classified job handed from front to back.
    typedef struct packed {
        logic [OPERAND_WIDTH-1:0] operand_a;
        logic [OPERAND_WIDTH-1:0] operand_b;
        logic                     has_zero;
    } gcdl_job_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GCD,
        ST_DIV,
        ST_MUL,
        ST_DONE
    } gcdl_state_t;

endpackage

/* design/gcdl_front.sv */
// Front end: input register and zero-operand classification.
module gcdl_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  gcdl_pkg::gcdl_in_t s_data,
    output logic               job_valid,
    input  logic               job_ready,
    output gcdl_pkg::gcdl_job_t job
);
    import gcdl_pkg::*;

    logic      valid_reg, valid_next;
    gcdl_job_t job_reg, job_next;
    logic      take;

    assign s_ready = !valid_reg || job_ready;
    assign take    = s_valid && s_ready;

    always_comb begin
        job_next           = job_reg;
        job_next.operand_a = s_data.operand_a;
        job_next.operand_b = s_data.operand_b;
        job_next.has_zero  = (s_data.operand_a == '0) || (s_data.operand_b == '0);
        if (take) begin
            valid_next = 1'b1;
        end else if (job_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (take) begin
            job_reg <= job_next;
        end
    end

    assign job_valid = valid_reg;
    assign job       = job_reg;

endmodule

/* design/gcdl_queue.sv */
// Short FIFO between front and back.
module gcdl_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push_valid,
    output logic                push_ready,
    input  gcdl_pkg::gcdl_job_t push_job,
    output logic                pop_valid,
    input  logic                pop_ready,
    output gcdl_pkg::gcdl_job_t pop_job
);
    import gcdl_pkg::*;

    gcdl_job_t             slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CW-1:0]   count_reg, count_next;
    logic                  do_push, do_pop;

    assign push_ready = (count_reg != QUEUE_CW'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_job    = slot_reg[rd_ptr_reg];

    function automatic logic [QUEUE_AW-1:0] ptr_inc(input logic [QUEUE_AW-1:0] p);
        if (p == QUEUE_AW'(QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    always_comb begin
        wr_ptr_next = do_push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

/* design/gcdl_back.sv */
// Back end: binary GCD, restoring divide a/g, then (a/g)*b.
module gcdl_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 job_valid,
    output logic                 job_ready,
    input  gcdl_pkg::gcdl_job_t  job,
    output logic                 res_valid,
    input  logic                 res_ready,
    output gcdl_pkg::gcdl_out_t  res
);
    import gcdl_pkg::*;

    localparam int W = OPERAND_WIDTH;

    gcdl_state_t         state_reg, state_next;
    logic [W-1:0]        x_reg, x_next;
    logic [W-1:0]        y_reg, y_next;
    logic [CNT_WIDTH-1:0] k_reg, k_next;
    logic [CNT_WIDTH-1:0] cnt_reg, cnt_next;
    logic [W-1:0]        a_reg, a_next;
    logic [W-1:0]        b_reg, b_next;
    logic [W-1:0]        g_reg, g_next;
    logic [W-1:0]        rem_reg, rem_next;
    logic [W-1:0]        quo_reg, quo_next;
    gcdl_out_t           res_reg, res_next;

    logic                gcd_end;
    logic [W:0]          rem_shift;
    logic                sub_ok;
    logic [W:0]          rem_diff;

    assign gcd_end   = (x_reg == '0) || (y_reg == '0);
    assign rem_shift = {rem_reg, quo_reg[W-1]};
    assign sub_ok    = rem_shift >= {1'b0, g_reg};
    assign rem_diff  = rem_shift - {1'b0, g_reg};

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (job_valid) begin
                    state_next = job.has_zero ? ST_DONE : ST_GCD;
                end
            end
            ST_GCD: begin
                if (gcd_end) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (cnt_reg == '0) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:  state_next = ST_DONE;
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        x_next    = x_reg;
        y_next    = y_reg;
        k_next    = k_reg;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        g_next    = g_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        res_next  = res_reg;
        job_ready = 1'b0;
        res_valid = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                job_ready = 1'b1;
                x_next    = job.operand_a;
                y_next    = job.operand_b;
                a_next    = job.operand_a;
                b_next    = job.operand_b;
                k_next    = '0;
                // zero operand: gcd is the other one, lcm is zero
                res_next.gcd_value = job.operand_a | job.operand_b;
                res_next.lcm_value = '0;
            end
            ST_GCD: begin
                if (gcd_end) begin
                    g_next   = (x_reg | y_reg) << k_reg;
                    rem_next = '0;
                    quo_next = a_reg;
                    cnt_next = CNT_WIDTH'(W - 1);
                end else begin
                    case ({x_reg[0], y_reg[0]})
                        2'b00: begin
                            x_next = x_reg >> 1;
                            y_next = y_reg >> 1;
                            k_next = k_reg + 1'b1;
                        end
                        2'b01: x_next = x_reg >> 1;
                        2'b10: y_next = y_reg >> 1;
                        default: begin
                            if (x_reg >= y_reg) begin
                                x_next = (x_reg - y_reg) >> 1;
                            end else begin
                                y_next = (y_reg - x_reg) >> 1;
                            end
                        end
                    endcase
                end
            end
            ST_DIV: begin
                rem_next = sub_ok ? rem_diff[W-1:0] : rem_shift[W-1:0];
                quo_next = {quo_reg[W-2:0], sub_ok};
                cnt_next = cnt_reg - 1'b1;
            end
            ST_MUL: begin
                res_next.gcd_value = g_reg;
                res_next.lcm_value = LCM_WIDTH'(quo_reg) * LCM_WIDTH'(b_reg);
            end
            ST_DONE: res_valid = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        x_reg   <= x_next;
        y_reg   <= y_next;
        k_reg   <= k_next;
        cnt_reg <= cnt_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        g_reg   <= g_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        res_reg <= res_next;
    end

    assign res = res_reg;

endmodule

/* design/gcd_lcm_unit.sv */
// Top level of the GCD / LCM unit: front, job queue, back end and output register.
//
//  channel | ports                     | item carries
//  --------+---------------------------+---------------------------------
//  input   | s_valid, s_ready, s_data  | operand_a, operand_b (16b each)
//  result  | m_valid, m_ready, m_data  | gcd_value (16b), lcm_value (32b)
//
// Timing: an item with a zero operand skips the GCD, divide and multiply steps.
// Otherwise the back end's binary GCD loop runs up to 2*16 steps, the restoring
// divider 16 steps, then one multiply; the back end takes no new item until
// its result has been passed to the output register.
// Reset: aresetn, synchronous, active low; clears handshake and FSM state only.
// Stalls: the front keeps taking items while the 2-entry queue has room; a result
// held by m_ready low blocks the back end, which then blocks the queue.
module gcd_lcm_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  gcdl_pkg::gcdl_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output gcdl_pkg::gcdl_out_t m_data
);
    import gcdl_pkg::*;

    // front -> queue
    logic      fq_valid, fq_ready;
    gcdl_job_t fq_job;
    // queue -> back
    logic      qb_valid, qb_ready;
    gcdl_job_t qb_job;
    // back -> output register
    logic      back_valid, out_load;
    gcdl_out_t back_res;

    logic      m_valid_reg, m_valid_next;
    gcdl_out_t m_data_reg;

    gcdl_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .job_valid (fq_valid),
        .job_ready (fq_ready),
        .job       (fq_job)
    );

    gcdl_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_job   (fq_job),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_job    (qb_job)
    );

    gcdl_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (qb_valid),
        .job_ready (qb_ready),
        .job       (qb_job),
        .res_valid (back_valid),
        .res_ready (out_load),
        .res       (back_res)
    );

    // output register: frees the back end as soon as a result is parked
    assign out_load = back_valid && (!m_valid_reg || m_ready);

    always_comb begin
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        if (out_load) begin
            m_data_reg <= back_res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // back end holds its result while the output register is occupied
    a_back_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        back_valid && !out_load |=> back_valid && $stable(back_res))
        else $error("back end result changed while blocked");

    // front holds its item while the queue is full
    a_front_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        fq_valid && !fq_ready |=> fq_valid && $stable(fq_job))
        else $error("front item changed while queue full");

    // zero gcd only for two zero operands, whose lcm is zero
    a_zero_gcd: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.gcd_value == '0) |-> (m_data.lcm_value == '0))
        else $error("zero gcd with nonzero lcm");

    // lcm nonzero implies gcd nonzero and no larger than lcm
    a_lcm_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.lcm_value != '0) |->
            (m_data.gcd_value != '0) &&
            (LCM_WIDTH'(m_data.gcd_value) <= m_data.lcm_value))
        else $error("lcm smaller than gcd");

endmodule
